// ===== hdl/shb_pkg.sv =====
package shb_pkg;

  localparam int CHAR_W   = 7;
  localparam int HASH_W   = 32;
  localparam int MULT_W   = 16;
  localparam int BUCKET_W = 16;
  localparam int SIZE_W   = 17;
  localparam int MODE_W   = 3;

  // Remainder unit: dividend is left-aligned in DVD_W bits, one bit per step.
  localparam int DVD_W    = 48;
  localparam int REM_W    = 17;
  localparam int CNT_W    = 6;

  // Significant dividend widths of each remainder job.
  localparam int W_MOD127 = 39;
  localparam int W_MOD7   = 35;
  localparam int W_UNIV   = 48;
  localparam int W_MULT   = 31;
  localparam int W_FINAL  = 32;

  localparam logic [MULT_W-1:0] MULT_START = 16'd31415;
  localparam logic [14:0]       MULT_STEP  = 15'd27183;
  localparam logic [5:0]        FIN_SCALE  = 6'd47;

  localparam logic [MODE_W-1:0] MODE_MOD127  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WRAP127 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UNIV    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PRIME   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MOD7    = 3'd4;

  localparam int APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-1:0] ADDR_NUM_BUCKETS = 3'd0;
  localparam logic [APB_ADDR_W-1:0] ADDR_HASH_MODE   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIVH,
    ST_MULA,
    ST_DIVA,
    ST_FIN,
    ST_DIVF,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    DS_MOD127,
    DS_MOD7,
    DS_UNIV,
    DS_MULT,
    DS_FIN_WRAP,
    DS_FIN_PRIME
  } div_src_t;

  typedef enum logic {
    HS_WRAP127,
    HS_PRIME
  } hash_step_t;

  typedef struct packed {
    logic       capture;
    logic       step_hash;
    hash_step_t step_sel;
    logic       load_div;
    div_src_t   div_src;
    logic       wr_hash_rem;
    logic       wr_mult_rem;
    logic       clear;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_status_t;

  function automatic logic [MODE_W-1:0] eff_mode(input logic [MODE_W-1:0] m);
    logic [MODE_W-1:0] r;
    if (m inside {[3'd5:3'd7]}) begin
      r = MODE_MOD127;
    end else begin
      r = m;
    end
    return r;
  endfunction

  // Weight of a character, picked by the character modulo 7. Since 8 is 1 modulo 7,
  // the octal digits are summed and folded once more.
  function automatic logic [5:0] char_weight(input logic [CHAR_W-1:0] c);
    logic [3:0] s1;
    logic [3:0] s2;
    logic [2:0] r;
    logic [5:0] w;
    s1 = {1'b0, c[2:0]} + {1'b0, c[5:3]} + {3'b0, c[6]};
    s2 = {1'b0, s1[2:0]} + {3'b0, s1[3]};
    if (s2 >= 4'd7) begin
      r = 3'(s2 - 4'd7);
    end else begin
      r = s2[2:0];
    end
    case (r)
      3'd0:    w = 6'd7;
      3'd1:    w = 6'd11;
      3'd2:    w = 6'd13;
      3'd3:    w = 6'd17;
      3'd4:    w = 6'd23;
      3'd5:    w = 6'd31;
      3'd6:    w = 6'd37;
      default: w = 6'd7;
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/shb_div.sv =====
module shb_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [shb_pkg::DVD_W-1:0] dividend,
  input  logic [shb_pkg::CNT_W-1:0] steps,
  input  logic [shb_pkg::REM_W-1:0] divisor,
  output logic                      busy,
  output logic [shb_pkg::REM_W-1:0] rem
);
  import shb_pkg::*;

  logic [DVD_W-1:0] dvd;
  logic [REM_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic [REM_W:0]   trial;
  logic             fits;

  assign busy  = (cnt != '0);
  assign trial = {rem, dvd[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= steps;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      if (fits) begin
        rem <= REM_W'(trial - {1'b0, dsr});
      end else begin
        rem <= REM_W'(trial);
      end
    end
  end

endmodule

// ===== hdl/shb_dp.sv =====
module shb_dp #(
  parameter int MAX_BUCKETS = 65536
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [shb_pkg::SIZE_W-1:0]   num_buckets,
  input  logic [shb_pkg::CHAR_W-1:0]   character,
  input  shb_pkg::dp_cmd_t             cmd,
  output shb_pkg::dp_status_t          status,
  output logic [shb_pkg::BUCKET_W-1:0] bucket
);
  import shb_pkg::*;

  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_BUCKETS);
  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);

  logic [CHAR_W-1:0]   chr;
  logic [HASH_W-1:0]   hash;
  logic [MULT_W-1:0]   mult;

  logic [SIZE_W-1:0]   size_eff;
  logic [SIZE_W-1:0]   size_m1;
  logic [W_MOD127-1:0] p_mod127;
  logic [W_MOD7-1:0]   p_mod7;
  logic [W_UNIV-1:0]   p_univ;
  logic [W_MULT-1:0]   p_mult;
  logic [HASH_W-1:0]   h_wrap127;
  logic [12:0]         wc;
  logic [HASH_W-1:0]   h_prime;
  logic [HASH_W-1:0]   n_scaled;

  logic [DVD_W-1:0]    div_dvd;
  logic [CNT_W-1:0]    div_steps;
  logic [REM_W-1:0]    div_dsr;
  logic                div_busy;
  logic [REM_W-1:0]    div_rem;

  function automatic logic [HASH_W-1:0] mag32(input logic [HASH_W-1:0] v);
    logic [HASH_W-1:0] r;
    if (v[HASH_W-1]) begin
      r = '0 - v;
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    if (num_buckets < SIZE_MIN) begin
      size_eff = SIZE_MIN;
    end else if (num_buckets > SIZE_MAX) begin
      size_eff = SIZE_MAX;
    end else begin
      size_eff = num_buckets;
    end
  end

  assign size_m1 = size_eff - 1'b1;

  // 127h and 7h are formed as shift and subtract.
  assign p_mod127  = W_MOD127'({hash, 7'b0}) - W_MOD127'(hash) + W_MOD127'(chr);
  assign p_mod7    = W_MOD7'({hash, 3'b0}) - W_MOD7'(hash) + W_MOD7'(chr);
  assign p_univ    = W_UNIV'(mult) * W_UNIV'(hash) + W_UNIV'(chr);
  assign p_mult    = W_MULT'(mult) * W_MULT'(MULT_STEP);
  assign h_wrap127 = HASH_W'(p_mod127);
  assign wc        = 13'(char_weight(chr)) * 13'(chr);
  assign h_prime   = hash + HASH_W'(wc);
  assign n_scaled  = hash * HASH_W'(FIN_SCALE);

  always_comb begin
    div_dsr = size_eff;
    case (cmd.div_src)
      DS_MOD127: begin
        div_dvd   = {p_mod127, {(DVD_W - W_MOD127){1'b0}}};
        div_steps = CNT_W'(W_MOD127);
      end
      DS_MOD7: begin
        div_dvd   = {p_mod7, {(DVD_W - W_MOD7){1'b0}}};
        div_steps = CNT_W'(W_MOD7);
      end
      DS_UNIV: begin
        div_dvd   = DVD_W'(p_univ);
        div_steps = CNT_W'(W_UNIV);
      end
      DS_MULT: begin
        div_dvd   = {p_mult, {(DVD_W - W_MULT){1'b0}}};
        div_steps = CNT_W'(W_MULT);
        div_dsr   = size_m1;
      end
      DS_FIN_WRAP: begin
        div_dvd   = {mag32(hash), {(DVD_W - W_FINAL){1'b0}}};
        div_steps = CNT_W'(W_FINAL);
      end
      DS_FIN_PRIME: begin
        div_dvd   = {mag32(n_scaled), {(DVD_W - W_FINAL){1'b0}}};
        div_steps = CNT_W'(W_FINAL);
      end
      default: begin
        div_dvd   = '0;
        div_steps = '0;
      end
    endcase
  end

  shb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load_div),
    .dividend (div_dvd),
    .steps    (div_steps),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  assign status.div_busy = div_busy;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      chr <= character;
    end
    if (cmd.load_out) begin
      bucket <= hash[BUCKET_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      hash <= '0;
      mult <= MULT_START;
    end else begin
      if (cmd.step_hash) begin
        if (cmd.step_sel == HS_PRIME) begin
          hash <= h_prime;
        end else begin
          hash <= h_wrap127;
        end
      end else if (cmd.wr_hash_rem) begin
        hash <= HASH_W'(div_rem);
      end
      if (cmd.wr_mult_rem) begin
        mult <= MULT_W'(div_rem);
      end
    end
  end

endmodule

// ===== hdl/shb_ctrl.sv =====
module shb_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [shb_pkg::MODE_W-1:0] hash_mode,
  input  logic                       in_valid,
  input  logic                       last_char,
  input  logic                       out_stall,
  input  shb_pkg::dp_status_t        status,
  output logic                       in_stall,
  output logic                       out_valid,
  output shb_pkg::dp_cmd_t           cmd
);
  import shb_pkg::*;

  state_t            state;
  state_t            state_next;
  logic              last;
  logic              out_valid_next;
  logic              out_free;
  logic [MODE_W-1:0] mode;

  assign mode     = eff_mode(hash_mode);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      last      <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (cmd.capture) begin
        last <= last_char;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (mode == MODE_WRAP127 || mode == MODE_PRIME) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_DIVH;
        end
      end
      ST_DIVH: begin
        if (!status.div_busy) begin
          state_next = (mode == MODE_UNIV) ? ST_MULA : ST_FIN;
        end
      end
      ST_MULA: state_next = ST_DIVA;
      ST_DIVA: begin
        if (!status.div_busy) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!last) begin
          state_next = ST_IDLE;
        end else if (mode == MODE_WRAP127 || mode == MODE_PRIME) begin
          state_next = ST_DIVF;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_DIVF: begin
        if (!status.div_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.step_sel   = HS_WRAP127;
    cmd.div_src    = DS_MOD127;
    in_stall       = rst || (state != ST_IDLE);
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        cmd.capture = in_valid && !rst;
      end
      ST_STEP: begin
        case (mode)
          MODE_WRAP127: begin
            cmd.step_hash = 1'b1;
            cmd.step_sel  = HS_WRAP127;
          end
          MODE_PRIME: begin
            cmd.step_hash = 1'b1;
            cmd.step_sel  = HS_PRIME;
          end
          MODE_UNIV: begin
            cmd.load_div = 1'b1;
            cmd.div_src  = DS_UNIV;
          end
          MODE_MOD7: begin
            cmd.load_div = 1'b1;
            cmd.div_src  = DS_MOD7;
          end
          default: begin
            cmd.load_div = 1'b1;
            cmd.div_src  = DS_MOD127;
          end
        endcase
      end
      ST_DIVH: cmd.wr_hash_rem = !status.div_busy;
      ST_MULA: begin
        cmd.load_div = 1'b1;
        cmd.div_src  = DS_MULT;
      end
      ST_DIVA: cmd.wr_mult_rem = !status.div_busy;
      ST_FIN: begin
        if (last && mode == MODE_WRAP127) begin
          cmd.load_div = 1'b1;
          cmd.div_src  = DS_FIN_WRAP;
        end else if (last && mode == MODE_PRIME) begin
          cmd.load_div = 1'b1;
          cmd.div_src  = DS_FIN_PRIME;
        end
      end
      ST_DIVF: cmd.wr_hash_rem = !status.div_busy;
      ST_EMIT: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          cmd.clear      = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/string_bucket_hash_top.sv =====
// Channel  | Beat carries               | Handshake
// ---------+----------------------------+------------------------------------
// input    | character, last_char       | in_valid / in_stall
// output   | bucket                     | out_valid / out_stall
// config   | num_buckets, hash_mode     | APB write at psel & penable & pwrite
//
// One character is worked on at a time; in modes 0, 4 and 2 a beat waits on the serial
// remainder unit, which retires one dividend bit per cycle (39, 35, then 48 + 31 bits),
// while modes 1 and 3 step the hash without it. A final character adds a 32-bit
// remainder pass in modes 1 and 3, then the output load in every mode, and waits
// further while an earlier result beat is still stalled.
// Reset is synchronous and active high; it restores the defaults and the hash state.
module string_bucket_hash_top #(
  parameter int MAX_BUCKETS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [6:0]  character,
  input  logic        last_char,
  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] bucket
);
  import shb_pkg::*;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd71;

  logic [SIZE_W-1:0] num_buckets;
  logic [MODE_W-1:0] hash_mode;
  logic              cfg_wr;
  dp_cmd_t           cmd;
  dp_status_t        status;

  // The registers are decoded on the word address alone; byte lanes are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_buckets <= SIZE_RESET;
      hash_mode   <= MODE_MOD127;
    end else if (cfg_wr) begin
      if (paddr[2] == ADDR_NUM_BUCKETS[2]) begin
        num_buckets <= pwdata[SIZE_W-1:0];
      end else begin
        hash_mode <= pwdata[MODE_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ADDR_HASH_MODE[2]) begin
      prdata = {{(32 - MODE_W){1'b0}}, hash_mode};
    end else begin
      prdata = {{(32 - SIZE_W){1'b0}}, num_buckets};
    end
  end

  // The controller sequences each character through the datapath; the datapath
  // holds the running hash, the mode 2 multiplier and the shared remainder unit.
  shb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .hash_mode (hash_mode),
    .in_valid  (in_valid),
    .last_char (last_char),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  shb_dp #(
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .num_buckets (num_buckets),
    .character   (character),
    .cmd         (cmd),
    .status      (status),
    .bucket      (bucket)
  );

endmodule

// ===== hdl/shb_checker.sv =====
module shb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] bucket
);

  // A waiting result beat keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bucket))
    else $error("output beat changed while stalled");

  // Characters are worked on one at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a character is still in work");

  // No result is left over from before reset.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // A new result only appears out of a busy cycle.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

endmodule

bind string_bucket_hash_top shb_checker u_shb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .bucket    (bucket)
);

// ===== tb/sv/shb_bucket_checker.sv =====
`timescale 1ns / 100ps

// Watches the configuration port and both channels, keeps its own image of the
// hash state and compares every bucket beat against the predicted one.
module shb_bucket_checker #(
  parameter int MAX_BUCKETS = 65536
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [shb_pkg::CHAR_W-1:0]   character,
  input  logic                         last_char,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [shb_pkg::BUCKET_W-1:0] bucket,
  output int unsigned                  mismatches,
  output int unsigned                  buckets_due
);
  import shb_pkg::*;

  localparam longint unsigned WIDE_MULT = 127;
  localparam longint unsigned NARROW_MULT = 7;
  localparam longint unsigned UNIV_STEP = 27183;
  localparam logic [HASH_W-1:0] SPREAD = 32'd47;

  logic [SIZE_W-1:0]   size_reg;
  logic [MODE_W-1:0]   mode_reg;
  logic [HASH_W-1:0]   hash_acc;
  logic [MULT_W-1:0]   mult_acc;
  logic [BUCKET_W-1:0] due_q[$];

  function automatic longint unsigned bucket_span(input logic [SIZE_W-1:0] s);
    longint unsigned span;
    span = s;
    if (span < 2) begin
      span = 2;
    end else if (span > MAX_BUCKETS) begin
      span = MAX_BUCKETS;
    end
    return span;
  endfunction

  function automatic logic [HASH_W-1:0] magnitude(input logic [HASH_W-1:0] v);
    return v[HASH_W-1] ? (32'd0 - v) : v;
  endfunction

  function automatic longint unsigned prime_weight(input logic [CHAR_W-1:0] c);
    longint unsigned w;
    case (c % 7)
      0:       w = 7;
      1:       w = 11;
      2:       w = 13;
      3:       w = 17;
      4:       w = 23;
      5:       w = 31;
      default: w = 37;
    endcase
    return w;
  endfunction

  // Folds one character into the running hash; a final character queues its bucket.
  task automatic absorb_char(input logic [CHAR_W-1:0] c, input logic fin);
    longint unsigned span;
    longint unsigned h;
    longint unsigned a;
    longint unsigned cw;
    logic [MODE_W-1:0] md;
    logic [HASH_W-1:0] folded;
    span = bucket_span(size_reg);
    h = hash_acc;
    cw = c;
    md = (mode_reg > MODE_MOD7) ? MODE_MOD127 : mode_reg;
    case (md)
      MODE_WRAP127: begin
        h = (WIDE_MULT * h + cw) & 64'hFFFF_FFFF;
      end
      MODE_UNIV: begin
        a = mult_acc;
        h = (a * h + cw) % span;
        mult_acc = MULT_W'((a * UNIV_STEP) % (span - 1));
      end
      MODE_PRIME: begin
        h = (h + prime_weight(c) * cw) & 64'hFFFF_FFFF;
      end
      MODE_MOD7: begin
        h = (NARROW_MULT * h + cw) % span;
      end
      default: begin
        h = (WIDE_MULT * h + cw) % span;
      end
    endcase
    hash_acc = h[HASH_W-1:0];
    if (fin) begin
      if (md == MODE_WRAP127) begin
        folded = magnitude(hash_acc);
      end else if (md == MODE_PRIME) begin
        folded = magnitude(hash_acc * SPREAD);
      end else begin
        folded = hash_acc;
      end
      due_q.push_back(BUCKET_W'({32'd0, folded} % span));
      hash_acc = '0;
      mult_acc = MULT_START;
    end
  endtask

  always @(posedge clk) begin
    logic [BUCKET_W-1:0] want;
    if (rst) begin
      size_reg = SIZE_W'(71);
      mode_reg = MODE_MOD127;
      hash_acc = '0;
      mult_acc = MULT_START;
      mismatches = 0;
      due_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_NUM_BUCKETS: size_reg = pwdata[SIZE_W-1:0];
          ADDR_HASH_MODE:   mode_reg = pwdata[MODE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: bucket %0d arrived with no string pending", $realtime, bucket);
          end
        end else begin
          want = due_q.pop_front();
          if (bucket !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: bucket mismatch, expected %0d, got %0d", $realtime, want, bucket);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        absorb_char(character, last_char);
      end
    end
    buckets_due <= due_q.size();
  end

endmodule

// ===== tb/sv/tb_string_bucket_hash_top.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the string bucket hash. The checker beside the block
// predicts every bucket from the configuration writes and the character beats it
// sees, so this module only has to make traffic and wait for the checker to drain.
module tb_string_bucket_hash_top;
  import shb_pkg::*;

  // The slowest character is one in universal mode; this margin covers a character
  // still being worked on when the queue is empty.
  localparam int SETTLE_CYCLES = 200;
  localparam int SEGMENTS = 16;
  localparam int CHARS_PER_SEGMENT = 68;
  localparam int MAX_STRING = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [6:0]  character = '0;
  logic        last_char = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] bucket;

  int unsigned mismatches;
  int unsigned buckets_due;

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  // Characters still to come in the string currently being sent.
  int unsigned chars_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  string_bucket_hash_top dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .character (character),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bucket    (bucket)
  );

  shb_bucket_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .character   (character),
    .last_char   (last_char),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bucket      (bucket),
    .mismatches  (mismatches),
    .buckets_due (buckets_due)
  );

  // The receiver decides afresh every cycle whether to stall the output beat.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // One APB write: a setup cycle, then the access cycle, which completes at the
  // edge where pready is seen high. psel is left high so that a second write can
  // follow straight on; the caller closes the transfer.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Writes both registers back to back and then releases the bus.
  task automatic configure(input logic [31:0] size, input logic [MODE_W-1:0] mode);
    apb_write(ADDR_NUM_BUCKETS, size);
    apb_write(ADDR_HASH_MODE, {29'd0, mode});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one character beat, after a random number of idle cycles, and returns
  // at the edge where it is taken. Valid is only lowered in cycles of idling, so a
  // beat that follows straight on keeps valid high without a glitch.
  task automatic send_char(input logic [6:0] c, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    character <= c;
    last_char <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  // Lets the block run dry: every predicted bucket must have been taken, and the
  // settle period allows for a character that produces no result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (buckets_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sends the next character of an endless run of random strings. Strings are
  // allowed to straddle a configuration change, which is how settings change in
  // the middle of a string in the random part.
  task automatic next_random_char();
    if (chars_left == 0) begin
      chars_left = $urandom_range(MAX_STRING, 1);
    end
    send_char(7'($urandom_range(127)), chars_left == 1);
    chars_left--;
  endtask

  // A random table size: mostly anywhere in range, sometimes tiny, sometimes one
  // of the saturating or boundary values, sometimes any 17-bit pattern at all.
  function automatic logic [31:0] pick_size();
    logic [31:0] s;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(6))
          0:       s = 32'd0;
          1:       s = 32'd1;
          2:       s = 32'd2;
          3:       s = 32'd65535;
          4:       s = 32'd65536;
          5:       s = 32'd65537;
          default: s = 32'd131071;
        endcase
      end
      1:       s = $urandom_range(20, 2);
      2:       s = $urandom_range(131071);
      default: s = $urandom_range(65536, 2);
    endcase
    return s;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed strings, sent without idling. First the reset defaults, with the
    // largest, zero and smallest nonzero character values.
    send_char(7'd127, 1'b0);
    send_char(7'd0, 1'b0);
    send_char(7'd1, 1'b1);
    drain();

    // A zero table size acts as two; a run of large characters in the wrapping
    // mode overflows 32 bits so that the magnitude matters.
    configure(32'd0, MODE_WRAP127);
    repeat (4) send_char(7'd127, 1'b0);
    send_char(7'd127, 1'b1);
    drain();

    // An over-range size saturates to the table maximum.
    configure(32'd131071, MODE_PRIME);
    send_char(7'd127, 1'b0);
    send_char(7'd126, 1'b0);
    send_char(7'd1, 1'b1);
    drain();

    // Universal mode with a size of one (acting as two), so the multiplier is
    // reduced modulo one, then with the largest table.
    configure(32'd1, MODE_UNIV);
    send_char(7'd100, 1'b0);
    send_char(7'd27, 1'b1);
    drain();
    configure(32'd65536, MODE_UNIV);
    repeat (2) send_char(7'd127, 1'b0);
    send_char(7'd127, 1'b1);
    drain();

    configure(32'd2, MODE_MOD7);
    send_char(7'd127, 1'b1);
    drain();

    // An unknown mode number behaves as the default mode.
    configure(32'd65537, 3'd7);
    send_char(7'd64, 1'b0);
    send_char(7'd63, 1'b1);
    drain();

    // Settings changed in the middle of a string: a large wrapped hash is carried
    // into the prime mode, whose scaled value then has its top bit set.
    configure(32'd1000, MODE_WRAP127);
    repeat (4) send_char(7'd127, 1'b0);
    drain();
    configure(32'd65535, MODE_PRIME);
    send_char(7'd0, 1'b1);
    drain();

    // Random part: each segment gets a fresh configuration and one of four idling
    // patterns, so that gaps and stalls fall on every phase of the work.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      configure(pick_size(), MODE_W'($urandom_range(7)));
      case (seg % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 71;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 71;
        end
        default: begin
          idle_pct = 18;
          stall_pct = 18;
        end
      endcase
      repeat (CHARS_PER_SEGMENT) next_random_char();
      drain();
    end

    // Finish the string left open by the last segment.
    while (chars_left != 0) next_random_char();
    drain();

    if (mismatches == 0) begin
      $display("[string_bucket_hash_top] OK");
    end else begin
      $display("[string_bucket_hash_top] ERROR");
    end
    $finish;
  end

  // Safety net well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("[string_bucket_hash_top] ERROR");
    $finish;
  end

endmodule
